// ===== rtl/square_channel_with_sweep_defines.svh =====
// assertion macros for the square channel with sweep
`ifndef SQUARE_CHANNEL_WITH_SWEEP_DEFINES_SVH
`define SQUARE_CHANNEL_WITH_SWEEP_DEFINES_SVH

// checked outside reset
`define SQCH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define SQCH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ===== rtl/sqch_pkg.sv =====
// types, codes and constants shared by the square channel with sweep
`timescale 1ns / 1ps

package sqch_pkg;

    localparam int FUNC_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int FREQ_W     = 11;
    localparam int PERIOD_W   = 12;
    localparam int ACCUM_W    = 16;
    localparam int LEVEL_W    = 4;
    localparam int POS_W      = 3;
    localparam int CNT_W      = 3;
    localparam int LEN_W      = 6;

    localparam logic [FUNC_W-1:0] FUNC_WR_SWEEP    = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_DUTY_LEN = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_ENVELOPE = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_WR_FREQ_LOW = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_WR_CONTROL  = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE     = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_LENGTH_TICK = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_ENV_TICK    = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP_TICK  = 4'd8;

    localparam logic [PERIOD_W-1:0] FREQ_SPAN  = 12'd2048;
    localparam logic [ACCUM_W-1:0]  ACCUM_MAX  = 16'hFFFF;
    localparam logic [BYTE_W-1:0]   DAC_MASK   = 8'hF8;
    localparam logic [LEVEL_W-1:0]  VOLUME_MAX = 4'hF;

    localparam int TRIGGER_BIT    = 7;
    localparam int LEN_ENABLE_BIT = 6;
    localparam int ENV_UP_BIT     = 3;
    localparam int SWEEP_DOWN_BIT = 3;

    // duty patterns, bit index is the duty position
    localparam logic [7:0] DUTY_PATTERN [4] = '{
        8'b1000_0000,
        8'b1000_0001,
        8'b0000_1111,
        8'b0111_1110
    };

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] mcycles;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] sample_level;
        logic               channel_on;
        logic [POS_W-1:0]   duty_position;
    } out_item_t;

    function automatic logic duty_bit(input logic [1:0] sel, input logic [POS_W-1:0] pos);
        logic [7:0] pattern;
        pattern  = DUTY_PATTERN[sel];
        duty_bit = pattern[pos];
    endfunction

endpackage

// ===== rtl/sqch_in_stage.sv =====
// input register for the event channel
`timescale 1ns / 1ps

module sqch_in_stage
    import sqch_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/sqch_core.sv =====
// channel registers and per-event state update
`timescale 1ns / 1ps

`include "square_channel_with_sweep_defines.svh"

module sqch_core
    import sqch_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      proc,
    input  in_item_t  in_item,
    output out_item_t result
);

    logic [BYTE_W-1:0]   sweep_reg, sweep_next;
    logic [BYTE_W-1:0]   duty_len_reg, duty_len_next;
    logic [BYTE_W-1:0]   envelope_reg, envelope_next;
    logic [BYTE_W-1:0]   freq_low_reg, freq_low_next;
    logic [BYTE_W-1:0]   control_reg, control_next;
    logic                enabled_reg, enabled_next;
    logic [ACCUM_W-1:0]  accum_reg, accum_next;
    logic [PERIOD_W-1:0] step_period_reg, step_period_next;
    logic [POS_W-1:0]    duty_pos_reg, duty_pos_next;
    logic [LEVEL_W-1:0]  volume_reg, volume_next;
    logic [CNT_W-1:0]    env_count_reg, env_count_next;
    logic [CNT_W-1:0]    sweep_count_reg, sweep_count_next;
    logic [FREQ_W-1:0]   shadow_reg, shadow_next;
    logic [LEN_W-1:0]    length_reg, length_next;

    logic [ACCUM_W:0]    accum_sum;
    logic [ACCUM_W-1:0]  accum_sat;
    logic [FREQ_W-1:0]   sweep_delta;
    logic [FREQ_W:0]     sweep_sum;
    logic [CNT_W-1:0]    env_inc;
    logic [CNT_W-1:0]    sweep_inc;
    logic [CNT_W-1:0]    env_pace;
    logic [CNT_W-1:0]    sweep_rate;
    logic [CNT_W-1:0]    sweep_shift;

    always_comb begin
        sweep_next       = sweep_reg;
        duty_len_next    = duty_len_reg;
        envelope_next    = envelope_reg;
        freq_low_next    = freq_low_reg;
        control_next     = control_reg;
        enabled_next     = enabled_reg;
        accum_next       = accum_reg;
        step_period_next = step_period_reg;
        duty_pos_next    = duty_pos_reg;
        volume_next      = volume_reg;
        env_count_next   = env_count_reg;
        sweep_count_next = sweep_count_reg;
        shadow_next      = shadow_reg;
        length_next      = length_reg;

        accum_sum   = {1'b0, accum_reg} + {{(ACCUM_W + 1 - BYTE_W){1'b0}}, in_item.mcycles};
        accum_sat   = accum_sum[ACCUM_W] ? ACCUM_MAX : accum_sum[ACCUM_W-1:0];
        env_pace    = envelope_reg[2:0];
        env_inc     = env_count_reg + 3'd1;
        sweep_rate  = sweep_reg[6:4];
        sweep_shift = sweep_reg[2:0];
        sweep_inc   = sweep_count_reg + 3'd1;
        sweep_delta = shadow_reg >> sweep_shift;
        sweep_sum   = sweep_reg[SWEEP_DOWN_BIT] ?
                      ({1'b0, shadow_reg} - {1'b0, sweep_delta}) :
                      ({1'b0, shadow_reg} + {1'b0, sweep_delta});

        if (proc) begin
            case (in_item.func)
                FUNC_WR_SWEEP: begin
                    sweep_next = in_item.data;
                end
                FUNC_WR_DUTY_LEN: begin
                    duty_len_next = in_item.data;
                end
                FUNC_WR_ENVELOPE: begin
                    envelope_next = in_item.data;
                end
                FUNC_WR_FREQ_LOW: begin
                    freq_low_next    = in_item.data;
                    step_period_next = FREQ_SPAN - {1'b0, control_reg[2:0], in_item.data};
                end
                FUNC_WR_CONTROL: begin
                    control_next = in_item.data;
                    if (in_item.data[TRIGGER_BIT]) begin
                        enabled_next     = 1'b1;
                        accum_next       = '0;
                        shadow_next      = {in_item.data[2:0], freq_low_reg};
                        step_period_next = FREQ_SPAN - {1'b0, in_item.data[2:0], freq_low_reg};
                        volume_next      = envelope_reg[7:4];
                    end
                    if (in_item.data[LEN_ENABLE_BIT]) begin
                        length_next = duty_len_reg[LEN_W-1:0];
                    end else begin
                        length_next = '0;
                    end
                end
                FUNC_ADVANCE: begin
                    if ((envelope_reg & DAC_MASK) == '0) begin
                        enabled_next = 1'b0;
                    end else if (accum_sat >= {{(ACCUM_W - PERIOD_W){1'b0}}, step_period_reg}) begin
                        duty_pos_next = duty_pos_reg + 3'd1;
                        accum_next    = accum_sat - {{(ACCUM_W - PERIOD_W){1'b0}}, step_period_reg};
                    end else begin
                        accum_next = accum_sat;
                    end
                end
                FUNC_LENGTH_TICK: begin
                    if (control_reg[LEN_ENABLE_BIT] && length_reg != '0) begin
                        length_next = length_reg - 6'd1;
                        if (length_reg == 6'd1) begin
                            enabled_next = 1'b0;
                        end
                    end
                end
                FUNC_ENV_TICK: begin
                    if (env_pace != '0) begin
                        if (env_inc >= env_pace) begin
                            env_count_next = '0;
                            if (envelope_reg[ENV_UP_BIT]) begin
                                if (volume_reg != VOLUME_MAX) begin
                                    volume_next = volume_reg + 4'd1;
                                end
                            end else if (volume_reg != '0) begin
                                volume_next = volume_reg - 4'd1;
                            end
                        end else begin
                            env_count_next = env_inc;
                        end
                    end
                end
                FUNC_SWEEP_TICK: begin
                    if (sweep_rate != '0 && sweep_shift != '0) begin
                        if (sweep_inc < sweep_rate) begin
                            sweep_count_next = sweep_inc;
                        end else begin
                            sweep_count_next = '0;
                            if (sweep_sum[FREQ_W]) begin
                                enabled_next = 1'b0;
                            end else begin
                                shadow_next      = sweep_sum[FREQ_W-1:0];
                                control_next     = {control_reg[7:3], sweep_sum[10:8]};
                                freq_low_next    = sweep_sum[7:0];
                                step_period_next = FREQ_SPAN - sweep_sum;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg       <= '0;
            duty_len_reg    <= '0;
            envelope_reg    <= '0;
            freq_low_reg    <= '0;
            control_reg     <= '0;
            enabled_reg     <= 1'b0;
            accum_reg       <= '0;
            step_period_reg <= FREQ_SPAN;
            duty_pos_reg    <= '0;
            volume_reg      <= '0;
            env_count_reg   <= '0;
            sweep_count_reg <= '0;
            shadow_reg      <= '0;
            length_reg      <= '0;
        end else begin
            sweep_reg       <= sweep_next;
            duty_len_reg    <= duty_len_next;
            envelope_reg    <= envelope_next;
            freq_low_reg    <= freq_low_next;
            control_reg     <= control_next;
            enabled_reg     <= enabled_next;
            accum_reg       <= accum_next;
            step_period_reg <= step_period_next;
            duty_pos_reg    <= duty_pos_next;
            volume_reg      <= volume_next;
            env_count_reg   <= env_count_next;
            sweep_count_reg <= sweep_count_next;
            shadow_reg      <= shadow_next;
            length_reg      <= length_next;
        end
    end

    // result reflects the state after the transaction
    always_comb begin
        result.sample_level  = duty_bit(duty_len_next[7:6], duty_pos_next) ? volume_next : '0;
        result.channel_on    = enabled_next;
        result.duty_position = duty_pos_next;
    end

    `SQCH_ASSERT(a_period_range, step_period_reg != '0 && step_period_reg <= FREQ_SPAN, "step period out of range")
    `SQCH_ASSERT(a_trigger_enables, proc && in_item.func == FUNC_WR_CONTROL && in_item.data[TRIGGER_BIT] |=> enabled_reg, "trigger did not enable channel")
    `SQCH_ASSERT(a_pos_holds_idle, !proc |=> $stable(duty_pos_reg), "duty position moved without a transaction")
    `SQCH_ASSERT_ALWAYS(a_reset_state, !aresetn |=> !enabled_reg && step_period_reg == FREQ_SPAN, "reset state wrong")

endmodule

// ===== rtl/sqch_out_stage.sv =====
// result register for the result channel
`timescale 1ns / 1ps

module sqch_out_stage
    import sqch_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_item_t result,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

// ===== rtl/square_channel_with_sweep.sv =====
// top level of the pulse channel with frequency sweep
// a transaction passes the input register, then the result register, to reach m_item
// throughput: one per cycle unless stalled; the state update is a single registered step
// the input register refills in the cycle its transaction moves into the result register
// reset: synchronous active-low aresetn clears both valid flags and all channel state
// after reset the step period is 2048 and every other channel register is zero
`timescale 1ns / 1ps

module square_channel_with_sweep
    import sqch_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      item_valid;
    in_item_t  item;
    logic      can_load;
    logic      proc;
    out_item_t result;

    assign proc = item_valid && can_load;

    sqch_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (proc),
        .item_valid (item_valid),
        .item       (item)
    );

    sqch_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (proc),
        .in_item (item),
        .result  (result)
    );

    sqch_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// ===== sim/square_channel_with_sweep_tb.sv =====
// self-checking testbench for the pulse channel with sweep: directed table, random notes, idling
`timescale 1ns / 1ps

module square_channel_with_sweep_tb;
    import sqch_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 200;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int DRONE_STEPS     = 300;
    localparam int NUM_PHASES      = 4;
    localparam int TX_IDLE_PCT [NUM_PHASES]  = '{0, 57, 0, 23};
    localparam int RX_STALL_PCT [NUM_PHASES] = '{0, 0, 57, 23};

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = FUNC_SWEEP_TICK + 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_LAST         = {FUNC_W{1'b1}};

    // bit n is the level at duty step n
    localparam logic [7:0] DUTY_WAVE [4] = '{
        8'b1000_0000,
        8'b1000_0001,
        8'b0000_1111,
        8'b0111_1110
    };

    typedef struct packed {
        in_item_t  stim;
        logic      has_fixed;
        out_item_t fixed_want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 26;
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // dac off right after reset
        '{'{FUNC_ADVANCE,     8'h00, 8'hFF}, 1'b1, '{4'd0, 1'b0, 3'd0}},
        '{'{FUNC_LAST,        8'hFF, 8'hFF}, 1'b1, '{4'd0, 1'b0, 3'd0}},
        // trigger with dac off, then switched off by the next advance
        '{'{FUNC_WR_CONTROL,  8'h80, 8'h00}, 1'b1, '{4'd0, 1'b1, 3'd0}},
        '{'{FUNC_ADVANCE,     8'h00, 8'h01}, 1'b1, '{4'd0, 1'b0, 3'd0}},
        '{'{FUNC_WR_ENVELOPE, 8'hF1, 8'h00}, 1'b0, '0},
        '{'{FUNC_WR_DUTY_LEN, 8'h42, 8'h00}, 1'b0, '0},
        '{'{FUNC_WR_SWEEP,    8'h11, 8'h00}, 1'b0, '0},
        '{'{FUNC_WR_FREQ_LOW, 8'hFF, 8'h00}, 1'b0, '0},
        // top frequency, step period of 1, full volume
        '{'{FUNC_WR_CONTROL,  8'hC7, 8'h00}, 1'b1, '{4'd15, 1'b1, 3'd0}},
        '{'{FUNC_ADVANCE,     8'hFF, 8'hFF}, 1'b0, '0},
        '{'{FUNC_ENV_TICK,    8'h00, 8'h00}, 1'b0, '0},
        // length runs out
        '{'{FUNC_LENGTH_TICK, 8'h00, 8'h00}, 1'b0, '0},
        '{'{FUNC_LENGTH_TICK, 8'hFF, 8'hFF}, 1'b0, '0},
        // sweep overflow
        '{'{FUNC_WR_CONTROL,  8'h87, 8'h00}, 1'b0, '0},
        '{'{FUNC_SWEEP_TICK,  8'h00, 8'h00}, 1'b0, '0},
        // downward sweep updates frequency and period
        '{'{FUNC_WR_SWEEP,    8'h1F, 8'h00}, 1'b0, '0},
        '{'{FUNC_WR_CONTROL,  8'h87, 8'h00}, 1'b0, '0},
        '{'{FUNC_SWEEP_TICK,  8'hFF, 8'h00}, 1'b0, '0},
        // volume saturates high
        '{'{FUNC_WR_ENVELOPE, 8'h09, 8'h00}, 1'b0, '0},
        '{'{FUNC_ENV_TICK,    8'h00, 8'hFF}, 1'b0, '0},
        // volume saturates low
        '{'{FUNC_WR_ENVELOPE, 8'h11, 8'h00}, 1'b0, '0},
        '{'{FUNC_WR_CONTROL,  8'h80, 8'h00}, 1'b0, '0},
        '{'{FUNC_ENV_TICK,    8'h00, 8'h00}, 1'b0, '0},
        '{'{FUNC_ENV_TICK,    8'h00, 8'h00}, 1'b0, '0},
        // control writes without trigger load or clear the length
        '{'{FUNC_WR_CONTROL,  8'h40, 8'h00}, 1'b0, '0},
        '{'{FUNC_WR_CONTROL,  8'h00, 8'h00}, 1'b0, '0}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // expectation carried along with the offered transaction
    logic      cur_fixed = 1'b0;
    out_item_t cur_want  = '0;

    // channel state of the predictor
    logic [7:0]          sw_reg  = '0;
    logic [7:0]          dl_reg  = '0;
    logic [7:0]          env_reg = '0;
    logic [7:0]          flo_reg = '0;
    logic [7:0]          ctl_reg = '0;
    logic                ch_on   = 1'b0;
    logic [ACCUM_W-1:0]  accum   = '0;
    logic [PERIOD_W-1:0] period  = FREQ_SPAN;
    logic [POS_W-1:0]    pos     = '0;
    logic [LEVEL_W-1:0]  vol     = '0;
    logic [CNT_W-1:0]    env_cnt = '0;
    logic [CNT_W-1:0]    sw_cnt  = '0;
    logic [FREQ_W-1:0]   shadow  = '0;
    logic [LEN_W-1:0]    len_cnt = '0;

    out_item_t pending_samples [$];

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned phase_items   = 0;
    int unsigned trigger_count = 0;
    int unsigned overflow_count = 0;
    int unsigned saturate_count = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    int          cycle_count   = 0;

    square_channel_with_sweep u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_samples.size());
            $display("** square_channel_with_sweep: FAILED **");
            $finish;
        end
    end

    function automatic out_item_t predict_channel(input in_item_t ev);
        out_item_t          r;
        logic [ACCUM_W:0]   sum;
        logic [PERIOD_W-1:0] nxt;
        logic [7:0]         wave;
        case (ev.func)
            FUNC_WR_SWEEP:    sw_reg = ev.data;
            FUNC_WR_DUTY_LEN: dl_reg = ev.data;
            FUNC_WR_ENVELOPE: env_reg = ev.data;
            FUNC_WR_FREQ_LOW: begin
                flo_reg = ev.data;
                period  = FREQ_SPAN - {1'b0, ctl_reg[2:0], ev.data};
            end
            FUNC_WR_CONTROL: begin
                ctl_reg = ev.data;
                if (ev.data[TRIGGER_BIT]) begin
                    trigger_count++;
                    ch_on  = 1'b1;
                    accum  = '0;
                    shadow = {ev.data[2:0], flo_reg};
                    period = FREQ_SPAN - {1'b0, shadow};
                    vol    = env_reg[7:4];
                end
                len_cnt = ev.data[LEN_ENABLE_BIT] ? dl_reg[LEN_W-1:0] : '0;
            end
            FUNC_ADVANCE: begin
                if ((env_reg & DAC_MASK) == '0) begin
                    ch_on = 1'b0;
                end else begin
                    sum = {1'b0, accum} + {{(ACCUM_W + 1 - BYTE_W){1'b0}}, ev.mcycles};
                    if (sum[ACCUM_W]) begin
                        saturate_count++;
                        accum = ACCUM_MAX;
                    end else begin
                        accum = sum[ACCUM_W-1:0];
                    end
                    if (accum >= {{(ACCUM_W - PERIOD_W){1'b0}}, period}) begin
                        pos   = pos + 3'd1;
                        accum = accum - {{(ACCUM_W - PERIOD_W){1'b0}}, period};
                    end
                end
            end
            FUNC_LENGTH_TICK: begin
                if (ctl_reg[LEN_ENABLE_BIT] && len_cnt != 0) begin
                    len_cnt = len_cnt - 6'd1;
                    if (len_cnt == 0)
                        ch_on = 1'b0;
                end
            end
            FUNC_ENV_TICK: begin
                if (env_reg[2:0] != 0) begin
                    env_cnt = env_cnt + 3'd1;
                    if (env_cnt >= env_reg[2:0]) begin
                        env_cnt = '0;
                        if (env_reg[ENV_UP_BIT]) begin
                            if (vol != VOLUME_MAX)
                                vol = vol + 4'd1;
                        end else if (vol != 0) begin
                            vol = vol - 4'd1;
                        end
                    end
                end
            end
            FUNC_SWEEP_TICK: begin
                if (sw_reg[6:4] != 0 && sw_reg[2:0] != 0) begin
                    sw_cnt = sw_cnt + 3'd1;
                    if (sw_cnt >= sw_reg[6:4]) begin
                        sw_cnt = '0;
                        if (sw_reg[SWEEP_DOWN_BIT])
                            nxt = {1'b0, shadow} - ({1'b0, shadow} >> sw_reg[2:0]);
                        else
                            nxt = {1'b0, shadow} + ({1'b0, shadow} >> sw_reg[2:0]);
                        // past the 11-bit frequency range
                        if (nxt[FREQ_W]) begin
                            overflow_count++;
                            ch_on = 1'b0;
                        end else begin
                            shadow       = nxt[FREQ_W-1:0];
                            ctl_reg[2:0] = nxt[10:8];
                            flo_reg      = nxt[7:0];
                            period       = FREQ_SPAN - nxt;
                        end
                    end
                end
            end
            default: ;
        endcase
        wave            = DUTY_WAVE[dl_reg[7:6]];
        r.sample_level  = wave[pos] ? vol : '0;
        r.channel_on    = ch_on;
        r.duty_position = pos;
        return r;
    endfunction

    task automatic flag_error(input string what, input out_item_t want, input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d %s: expected level %0d on %0b pos %0d, got level %0d on %0b pos %0d",
                     results_seen, what, want.sample_level, want.channel_on,
                     want.duty_position, got.sample_level, got.channel_on, got.duty_position);
    endtask

    always @(posedge aclk) begin
        out_item_t pred;
        out_item_t want;
        if (aresetn && s_valid && s_ready) begin
            pred = predict_channel(s_item);
            pending_samples.push_back(cur_fixed ? cur_want : pred);
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_samples.size() == 0) begin
                flag_error("with nothing pending", '0, m_item);
            end else begin
                want = pending_samples.pop_front();
                if (m_item.sample_level !== want.sample_level)
                    flag_error("level mismatch", want, m_item);
                else if (m_item.channel_on !== want.channel_on)
                    flag_error("enable mismatch", want, m_item);
                else if (m_item.duty_position !== want.duty_position)
                    flag_error("position mismatch", want, m_item);
            end
        end
    end

    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic send_event(input in_item_t ev, input logic fixed, input out_item_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_item    <= ev;
        cur_fixed <= fixed;
        cur_want  <= want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (ev.func <= FUNC_SWEEP_TICK)
            phase_items++;
    endtask

    task automatic send_rand(input logic [FUNC_W-1:0] f, input logic [7:0] d,
                             input logic [7:0] mc);
        in_item_t ev;
        ev.func    = f;
        ev.data    = d;
        ev.mcycles = mc;
        send_event(ev, 1'b0, '0);
    endtask

    function automatic logic [7:0] pick_mcycles();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_samples.size() != 0);
    endtask

    // program the channel, trigger it (mostly) and let it play
    task automatic play_note();
        logic [7:0]  env;
        logic [7:0]  ctl;
        int unsigned pick;
        env = 8'($urandom);
        if (env[7:3] == 0 && $urandom_range(9) != 0)
            env[7:4] = 4'($urandom_range(15, 1));
        ctl = 8'($urandom);
        ctl[TRIGGER_BIT] = ($urandom_range(9) != 0);
        send_rand(FUNC_WR_ENVELOPE, env, 8'($urandom));
        send_rand(FUNC_WR_DUTY_LEN, 8'($urandom), 8'($urandom));
        send_rand(FUNC_WR_SWEEP, 8'($urandom), 8'($urandom));
        send_rand(FUNC_WR_FREQ_LOW, 8'($urandom), 8'($urandom));
        send_rand(FUNC_WR_CONTROL, ctl, 8'($urandom));
        repeat ($urandom_range(40, 8)) begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_rand(FUNC_ADVANCE, 8'($urandom), pick_mcycles());
            else if (pick < 63)
                send_rand(FUNC_LENGTH_TICK, 8'($urandom), 8'($urandom));
            else if (pick < 76)
                send_rand(FUNC_ENV_TICK, 8'($urandom), 8'($urandom));
            else if (pick < 89)
                send_rand(FUNC_SWEEP_TICK, 8'($urandom), 8'($urandom));
            else if (pick < 96)
                send_rand(4'($urandom_range(FUNC_WR_CONTROL, FUNC_WR_SWEEP)),
                          8'($urandom), 8'($urandom));
            else
                send_rand(4'($urandom_range(FUNC_LAST, FUNC_UNUSED_FIRST)),
                          8'($urandom), 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_event(DIRECTED[i].stim, DIRECTED[i].has_fixed, DIRECTED[i].fixed_want);
        drain_results();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            tx_idle_pct  = TX_IDLE_PCT[phase];
            rx_stall_pct <= RX_STALL_PCT[phase];
            phase_items  = 0;
            if (phase == 0 || phase == NUM_PHASES - 1)
                hold_requests <= hold_requests + 1;
            if (phase == 0) begin
                // a step period of 1 with large advances drives the accumulator into its limit
                send_rand(FUNC_WR_ENVELOPE, 8'hF0, 8'($urandom));
                send_rand(FUNC_WR_FREQ_LOW, 8'hFF, 8'($urandom));
                send_rand(FUNC_WR_CONTROL, 8'h87, 8'($urandom));
                repeat (DRONE_STEPS)
                    send_rand(FUNC_ADVANCE, 8'($urandom), 8'($urandom_range(255, 200)));
            end
            while (phase_items < ITEMS_PER_PHASE) begin
                if ($urandom_range(9) < 8)
                    play_note();
                else
                    repeat ($urandom_range(8, 1))
                        send_rand(4'($urandom), 8'($urandom), 8'($urandom));
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        $display("checked %0d results over directed cases and %0d idling phases", results_seen,
                 NUM_PHASES);
        $display("saw %0d triggers, %0d sweep overflows, %0d accumulator saturations",
                 trigger_count, overflow_count, saturate_count);
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("** square_channel_with_sweep: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     pending_samples.size());
            $display("** square_channel_with_sweep: FAILED **");
        end
        $finish;
    end

endmodule
